/* rtl/core/rssa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rssa_pkg
// Shared types and constants of the revolved segment surface area block.
// ----------------------------------------------------------------------------
package rssa_pkg;

  // field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned AREA_W  = 64;
  localparam int unsigned MAG_W   = 64;
  localparam int unsigned SUM_W   = 65;
  localparam int unsigned SREM_W  = 66;
  localparam int unsigned WIN_W   = 68;

  // one quotient bit and one root bit per step
  localparam int unsigned STEPS = 64;

  // job queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // register port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_REVOLVE_ABOUT_X = 1'b0;
  localparam logic        REVOLVE_RESET       = 1'b1;

  // pi as floor(pi * 2^61)
  localparam logic [MAG_W-1:0] PI_Q61 = 64'h6487_ED51_10B4_611A;

  // final scaling per segment class
  localparam int unsigned SH_ANNULUS  = 77;
  localparam int unsigned SH_CYLINDER = 76;
  localparam int unsigned SH_CONE     = 73;

  typedef enum logic [1:0] {
    CLS_NOT_LINE,
    CLS_ANNULUS,
    CLS_CYLINDER,
    CLS_CONE
  } cls_e;

  // classified job handed from front to back
  typedef struct packed {
    cls_e             cls;
    logic             neg;
    logic [MAG_W-1:0] x;
    logic [31:0]      ad;
    logic [SUM_W-1:0] s;
  } seg_job_t;

  // state carried through the divide / square root steps
  typedef struct packed {
    cls_e              cls;
    logic              neg;
    logic [MAG_W-1:0]  x;
    logic [31:0]       ad;
    logic              sat;
    logic [31:0]       drem;
    logic [MAG_W-1:0]  dlow;
    logic [SREM_W-1:0] srem;
    logic [MAG_W-1:0]  root;
    logic [WIN_W-1:0]  win;
  } step_t;

endpackage
`default_nettype wire

/* rtl/core/rssa_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rssa_if
// Valid/ready channels for segment beats and area beats.
// ----------------------------------------------------------------------------
interface rssa_seg_if;
  logic                                valid;
  logic                                ready;
  logic signed [rssa_pkg::COORD_W-1:0] x_start;
  logic signed [rssa_pkg::COORD_W-1:0] y_start;
  logic signed [rssa_pkg::COORD_W-1:0] x_end;
  logic signed [rssa_pkg::COORD_W-1:0] y_end;
  logic                                is_line;

  modport source (output valid, x_start, y_start, x_end, y_end, is_line, input ready);
  modport sink (input valid, x_start, y_start, x_end, y_end, is_line, output ready);
endinterface

interface rssa_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [rssa_pkg::AREA_W-1:0] area;
  logic                               unsupported_cell;

  modport source (output valid, area, unsupported_cell, input ready);
  modport sink (input valid, area, unsupported_cell, output ready);
endinterface
`default_nettype wire

/* rtl/core/rssa_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rssa_front
// Orders the endpoints, forms the squares and classifies each segment.
// ----------------------------------------------------------------------------
module rssa_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               revolve_about_x_i,
  rssa_seg_if.sink           seg_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output rssa_pkg::seg_job_t q_job_o
);

  logic adv;
  logic f1_valid_q, f2_valid_q;

  // stage one: axis swap and endpoint order
  logic signed [31:0] ax0, ax1, rd0, rd1, na0, na1, nr0, nr1;
  logic               swap;
  logic [32:0]        da_diff, dr, ad_full;

  logic               f1_line_q;
  logic [31:0]        f1_da_q, f1_ad_q;
  logic signed [31:0] f1_r0_q, f1_r1_q;

  always_comb begin
    if (revolve_about_x_i) begin
      ax0 = seg_i.x_start; rd0 = seg_i.y_start;
      ax1 = seg_i.x_end;   rd1 = seg_i.y_end;
    end else begin
      ax0 = seg_i.y_start; rd0 = seg_i.x_start;
      ax1 = seg_i.y_end;   rd1 = seg_i.x_end;
    end
    swap    = ax1 < ax0;
    na0     = swap ? ax1 : ax0;
    na1     = swap ? ax0 : ax1;
    nr0     = swap ? rd1 : rd0;
    nr1     = swap ? rd0 : rd1;
    da_diff = {na1[31], na1} - {na0[31], na0};
    dr      = {nr1[31], nr1} - {nr0[31], nr0};
    ad_full = dr[32] ? (~dr + 33'd1) : dr;
  end

  // front stalls only on a full queue
  assign adv         = !f2_valid_q || !q_full_i;
  assign seg_i.ready = adv;
  assign q_push_o    = f2_valid_q && !q_full_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_line_q <= seg_i.is_line;
      f1_da_q   <= da_diff[31:0];
      f1_ad_q   <= ad_full[31:0];
      f1_r0_q   <= nr0;
      f1_r1_q   <= nr1;
    end
  end

  // stage two: magnitudes and products
  logic [31:0] m0, m1;
  logic [63:0] q0, q1, dd, aa, cyl;

  assign m0  = f1_r0_q[31] ? (~f1_r0_q + 32'd1) : f1_r0_q;
  assign m1  = f1_r1_q[31] ? (~f1_r1_q + 32'd1) : f1_r1_q;
  assign q0  = m0 * m0;
  assign q1  = m1 * m1;
  assign dd  = f1_da_q * f1_da_q;
  assign aa  = f1_ad_q * f1_ad_q;
  assign cyl = m0 * f1_da_q;

  logic [63:0] f2_q0_q, f2_q1_q, f2_dd_q, f2_aa_q, f2_cyl_q;
  logic [31:0] f2_ad_q;
  logic        f2_line_q, f2_r0neg_q, f2_r1neg_q, f2_m0lt_q, f2_r1lt_q;
  logic        f2_dazero_q, f2_adzero_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f2_q0_q     <= q0;
      f2_q1_q     <= q1;
      f2_dd_q     <= dd;
      f2_aa_q     <= aa;
      f2_cyl_q    <= cyl;
      f2_ad_q     <= f1_ad_q;
      f2_line_q   <= f1_line_q;
      f2_r0neg_q  <= f1_r0_q[31];
      f2_r1neg_q  <= f1_r1_q[31];
      f2_m0lt_q   <= m0 < m1;
      f2_r1lt_q   <= f1_r1_q < f1_r0_q;
      f2_dazero_q <= f1_da_q == 32'd0;
      f2_adzero_q <= f1_ad_q == 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= seg_i.valid;
      f2_valid_q <= f1_valid_q;
    end
  end

  // classification and signed numerators
  logic [63:0] qa, qb;
  logic [64:0] ann_d, s0, s1;
  logic [65:0] cone_n, cone_neg;
  logic [64:0] ann_neg;

  always_comb begin
    qa       = f2_r1lt_q ? f2_q0_q : f2_q1_q;
    qb       = f2_r1lt_q ? f2_q1_q : f2_q0_q;
    ann_d    = {1'b0, qa} - {1'b0, qb};
    ann_neg  = ~ann_d + 65'd1;
    s0       = f2_r0neg_q ? (~{1'b0, f2_q0_q} + 65'd1) : {1'b0, f2_q0_q};
    s1       = f2_r1neg_q ? (~{1'b0, f2_q1_q} + 65'd1) : {1'b0, f2_q1_q};
    cone_n   = f2_m0lt_q ? ({s1[64], s1} - {s0[64], s0}) : ({s0[64], s0} - {s1[64], s1});
    cone_neg = ~cone_n + 66'd1;

    q_job_o.ad = f2_ad_q;
    q_job_o.s  = {1'b0, f2_dd_q} + {1'b0, f2_aa_q};
    if (!f2_line_q) begin
      q_job_o.cls = rssa_pkg::CLS_NOT_LINE;
      q_job_o.neg = 1'b0;
      q_job_o.x   = '0;
    end else if (f2_dazero_q) begin
      q_job_o.cls = rssa_pkg::CLS_ANNULUS;
      q_job_o.neg = ann_d[64];
      q_job_o.x   = ann_d[64] ? ann_neg[63:0] : ann_d[63:0];
    end else if (f2_adzero_q) begin
      q_job_o.cls = rssa_pkg::CLS_CYLINDER;
      q_job_o.neg = f2_r0neg_q;
      q_job_o.x   = f2_cyl_q;
    end else begin
      q_job_o.cls = rssa_pkg::CLS_CONE;
      q_job_o.neg = cone_n[65];
      q_job_o.x   = cone_n[65] ? cone_neg[63:0] : cone_n[63:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rssa_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rssa_queue
// Short first-in first-out queue of classified jobs.
// ----------------------------------------------------------------------------
module rssa_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rssa_pkg::seg_job_t job_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output rssa_pkg::seg_job_t head_o
);

  rssa_pkg::seg_job_t                mem_q [rssa_pkg::QDEPTH];
  logic [rssa_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [rssa_pkg::QCNT_W-1:0]       cnt_q, cnt_d;

  assign full_o  = cnt_q == rssa_pkg::QCNT_W'(rssa_pkg::QDEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + rssa_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - rssa_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + rssa_pkg::QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + rssa_pkg::QPTR_W'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rssa_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rssa_step
// One registered step: a quotient bit of the ratio and a bit of the length.
// ----------------------------------------------------------------------------
module rssa_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  rssa_pkg::step_t job_i,
  output logic            valid_o,
  output rssa_pkg::step_t job_o
);

  logic [32:0]                  div_part, div_diff;
  logic                         div_ge;
  logic [rssa_pkg::WIN_W-1:0]   sq_part, sq_trial, sq_diff;
  logic                         sq_ge;
  rssa_pkg::step_t              nxt;

  // restoring divide and square root, one bit each
  always_comb begin
    div_part = {job_i.drem, job_i.dlow[63]};
    div_ge   = div_part >= {1'b0, job_i.ad};
    div_diff = div_part - {1'b0, job_i.ad};
    sq_part  = {job_i.srem, job_i.win[rssa_pkg::WIN_W-1 -: 2]};
    sq_trial = {2'b00, job_i.root, 2'b01};
    sq_ge    = sq_part >= sq_trial;
    sq_diff  = sq_part - sq_trial;

    nxt      = job_i;
    nxt.drem = div_ge ? div_diff[31:0] : div_part[31:0];
    nxt.dlow = {job_i.dlow[62:0], div_ge};
    nxt.srem = sq_ge ? sq_diff[rssa_pkg::SREM_W-1:0] : sq_part[rssa_pkg::SREM_W-1:0];
    nxt.root = {job_i.root[62:0], sq_ge};
    nxt.win  = {job_i.win[rssa_pkg::WIN_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      job_o <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= valid_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rssa_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rssa_back
// Ratio, length, pi scaling and rounding of each job; owns the result beat.
// ----------------------------------------------------------------------------
module rssa_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  rssa_pkg::seg_job_t q_head_i,
  output logic               q_pop_o,
  rssa_res_if.source         res_o
);

  logic adv;
  logic out_valid_q;
  logic [rssa_pkg::AREA_W-1:0] area_q;
  logic flag_q;

  // whole back end moves while the result register can take a beat
  assign adv     = !out_valid_q || res_o.ready;
  assign q_pop_o = adv && !q_empty_i;

  // divider and root setup
  rssa_pkg::step_t prep;
  logic [29:0]     num_hi;

  always_comb begin
    num_hi    = q_head_i.x[63:34];
    prep.cls  = q_head_i.cls;
    prep.neg  = q_head_i.neg;
    prep.x    = q_head_i.x;
    prep.ad   = q_head_i.ad;
    prep.sat  = {2'b00, num_hi} >= q_head_i.ad;
    prep.drem = {2'b00, num_hi};
    prep.dlow = {q_head_i.x[33:0], 30'd0};
    prep.srem = '0;
    prep.root = '0;
    prep.win  = {3'b000, q_head_i.s};
  end

  rssa_pkg::step_t stg   [rssa_pkg::STEPS+1];
  logic            stg_v [rssa_pkg::STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg[0] <= prep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v[0] <= 1'b0;
    end else if (adv) begin
      stg_v[0] <= !q_empty_i;
    end
  end

  // bit-serial divide and square root pipeline
  for (genvar k = 0; k < rssa_pkg::STEPS; k++) begin : g_step
    rssa_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (stg_v[k]),
      .job_i   (stg[k]),
      .valid_o (stg_v[k+1]),
      .job_o   (stg[k+1])
    );
  end

  // length times ratio, partial products
  rssa_pkg::step_t    last;
  logic [63:0]        ratio, len;
  logic [63:0]        lp00, lp01, lp10, lp11;

  assign last  = stg[rssa_pkg::STEPS];
  assign ratio = last.sat ? '1 : last.dlow;
  assign len   = last.root;
  assign lp00  = len[31:0]  * ratio[31:0];
  assign lp01  = len[31:0]  * ratio[63:32];
  assign lp10  = len[63:32] * ratio[31:0];
  assign lp11  = len[63:32] * ratio[63:32];

  logic                 m1_valid_q, m2_valid_q, m3_valid_q, m4_valid_q;
  rssa_pkg::cls_e       m1_cls_q, m2_cls_q, m3_cls_q, m4_cls_q;
  logic                 m1_neg_q, m2_neg_q, m3_neg_q, m4_neg_q;
  logic [63:0]          m1_x_q, m1_p00_q, m1_p01_q, m1_p10_q, m1_p11_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_cls_q <= last.cls;
      m1_neg_q <= last.neg;
      m1_x_q   <= last.x;
      m1_p00_q <= lp00;
      m1_p01_q <= lp01;
      m1_p10_q <= lp10;
      m1_p11_q <= lp11;
    end
  end

  // upper half of length times ratio, pick the scaled operand
  logic [33:0] mid;
  logic [63:0] p_hi, x_sel;

  always_comb begin
    mid   = {2'b00, m1_p00_q[63:32]} + {2'b00, m1_p01_q[31:0]} + {2'b00, m1_p10_q[31:0]};
    p_hi  = m1_p11_q + {32'd0, m1_p01_q[63:32]} + {32'd0, m1_p10_q[63:32]}
          + {62'd0, mid[33:32]};
    x_sel = (m1_cls_q == rssa_pkg::CLS_CONE) ? p_hi : m1_x_q;
  end

  logic [63:0] m2_x_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_cls_q <= m1_cls_q;
      m2_neg_q <= m1_neg_q;
      m2_x_q   <= x_sel;
    end
  end

  // operand times pi, partial products
  logic [63:0] pp00, pp01, pp10, pp11;
  logic [63:0] m3_p00_q, m3_p01_q, m3_p10_q, m3_p11_q;

  assign pp00 = m2_x_q[31:0]  * rssa_pkg::PI_Q61[31:0];
  assign pp01 = m2_x_q[31:0]  * rssa_pkg::PI_Q61[63:32];
  assign pp10 = m2_x_q[63:32] * rssa_pkg::PI_Q61[31:0];
  assign pp11 = m2_x_q[63:32] * rssa_pkg::PI_Q61[63:32];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m3_cls_q <= m2_cls_q;
      m3_neg_q <= m2_neg_q;
      m3_p00_q <= pp00;
      m3_p01_q <= pp01;
      m3_p10_q <= pp10;
      m3_p11_q <= pp11;
    end
  end

  // full product
  logic [127:0] full;
  logic [127:0] m4_full_q;

  assign full = {m3_p11_q, 64'd0} + {32'd0, m3_p01_q, 32'd0} + {32'd0, m3_p10_q, 32'd0}
              + {64'd0, m3_p00_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m4_cls_q  <= m3_cls_q;
      m4_neg_q  <= m3_neg_q;
      m4_full_q <= full;
    end
  end

  // round half up on the magnitude, then apply the sign
  logic [127:0]                rnd_sum;
  logic [rssa_pkg::MAG_W-1:0]  mag;
  logic [rssa_pkg::AREA_W-1:0] area_d;
  logic                        flag_d;

  always_comb begin
    rnd_sum = '0;
    mag     = '0;
    flag_d  = 1'b0;
    case (m4_cls_q)
      rssa_pkg::CLS_ANNULUS: begin
        rnd_sum = m4_full_q + (128'd1 << (rssa_pkg::SH_ANNULUS - 1));
        mag     = rssa_pkg::MAG_W'(rnd_sum >> rssa_pkg::SH_ANNULUS);
      end
      rssa_pkg::CLS_CYLINDER: begin
        rnd_sum = m4_full_q + (128'd1 << (rssa_pkg::SH_CYLINDER - 1));
        mag     = rssa_pkg::MAG_W'(rnd_sum >> rssa_pkg::SH_CYLINDER);
      end
      rssa_pkg::CLS_CONE: begin
        rnd_sum = m4_full_q + (128'd1 << (rssa_pkg::SH_CONE - 1));
        mag     = rssa_pkg::MAG_W'(rnd_sum >> rssa_pkg::SH_CONE);
      end
      default: begin
        flag_d = 1'b1;
      end
    endcase
    area_d = m4_neg_q ? (~mag + rssa_pkg::MAG_W'(1)) : mag;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      area_q <= area_d;
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q  <= 1'b0;
      m2_valid_q  <= 1'b0;
      m3_valid_q  <= 1'b0;
      m4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      m1_valid_q  <= stg_v[rssa_pkg::STEPS];
      m2_valid_q  <= m1_valid_q;
      m3_valid_q  <= m2_valid_q;
      m4_valid_q  <= m3_valid_q;
      out_valid_q <= m4_valid_q;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.area             = $signed(area_q);
  assign res_o.unsupported_cell = flag_q;

endmodule
`default_nettype wire

/* rtl/core/revolved_segment_surface_area.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// revolved_segment_surface_area
// Surface area swept by a 2D segment revolved about the x or the y axis.
// ----------------------------------------------------------------------------
// Segments enter as beats on seg_i (Q16.16 endpoints and an is_line flag);
// one area beat per segment leaves on res_o (signed Q48.16, unsupported_cell
// set and area zero for a cell that is not a line). Results come in order.
// The revolve_about_x register (byte address 0 of the register port) picks
// the axis; the user must write it only while no segment is in flight,
// since the block itself does not enforce this. It takes one segment per
// cycle while seg_i.ready is high; a result beat passes through the 64-step
// bit-serial divide and square root pipeline, plus two front stages, the
// queue, setup and five stages of product, pi scaling and rounding.
// The front (ordering, squares, classification) feeds a four-entry queue;
// the back moves only while its result register can take a beat, so a
// stalled receiver freezes the back while the front keeps filling the queue,
// after which seg_i.ready drops.
// Reset clears every valid flag and the queue and sets revolve_about_x to 1;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module revolved_segment_surface_area (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rssa_seg_if.sink                       seg_i,
  rssa_res_if.source                     res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rssa_pkg::PADDR_W-1:0]   paddr,
  input  logic [rssa_pkg::PDATA_W-1:0]   pwdata,
  output logic [rssa_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  // configuration register
  logic revolve_q, revolve_d;
  logic reg_hit;

  assign reg_hit = paddr[2] == rssa_pkg::REG_REVOLVE_ABOUT_X;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(rssa_pkg::PDATA_W-1){1'b0}}, revolve_q} : '0;

  always_comb begin
    revolve_d = revolve_q;
    if (psel && penable && pwrite && reg_hit) begin
      revolve_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      revolve_q <= rssa_pkg::REVOLVE_RESET;
    end else begin
      revolve_q <= revolve_d;
    end
  end

  logic               q_push, q_full, q_pop, q_empty;
  rssa_pkg::seg_job_t q_job, q_head;

  rssa_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .revolve_about_x_i (revolve_q),
    .seg_i             (seg_i),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_job_o           (q_job)
  );

  rssa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  rssa_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule
`default_nettype wire

/* rtl/core/rssa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rssa_checker
// Port-level checks of the revolved segment surface area block.
// ----------------------------------------------------------------------------
module rssa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [rssa_pkg::AREA_W-1:0]   area_i,
  input logic                          unsupported_cell_i
);

  // beat counters
  logic [31:0] in_cnt_q, out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (in_valid_i && in_ready_i)   in_cnt_q  <= in_cnt_q + 32'd1;
      if (out_valid_i && out_ready_i) out_cnt_q <= out_cnt_q + 32'd1;
    end
  end

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(area_i)
      && $stable(unsupported_cell_i))
    else $error("result beat changed while stalled");

  // no result without an outstanding segment
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |-> in_cnt_q != out_cnt_q)
    else $error("result beat without a pending segment");

  // unsupported cells report zero area
  a_unsup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && unsupported_cell_i |-> area_i == '0)
    else $error("unsupported cell with nonzero area");

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

endmodule

bind revolved_segment_surface_area rssa_checker u_rssa_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (seg_i.valid),
  .in_ready_i         (seg_i.ready),
  .out_valid_i        (res_o.valid),
  .out_ready_i        (res_o.ready),
  .area_i             (res_o.area),
  .unsupported_cell_i (res_o.unsupported_cell)
);
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for revolved_segment_surface_area. Segment beats come
// from a directed table and then random bursts. Each accepted beat is run
// through a local area predictor. Area beats are compared in order with the
// predictions while the axis register is switched between phases and the
// result side stalls at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned LATENCY   = 80;
  localparam int unsigned MAX_CYC   = 2000000;
  localparam int unsigned RAND_SEGS = 1900;

  typedef struct {
    logic signed [31:0] x_start;
    logic signed [31:0] y_start;
    logic signed [31:0] x_end;
    logic signed [31:0] y_end;
    logic               is_line;
    logic               typed;     // expected area given by hand
    logic signed [63:0] typed_area;
    logic               typed_unsup;
  } seg_t;

  typedef struct {
    logic signed [63:0] area;
    logic               unsup;
  } area_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [rssa_pkg::PADDR_W-1:0] paddr;
  logic [rssa_pkg::PDATA_W-1:0] pwdata;
  logic [rssa_pkg::PDATA_W-1:0] prdata;
  logic pready;

  rssa_seg_if seg ();
  rssa_res_if res ();

  revolved_segment_surface_area dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .seg_i   (seg),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic  axis_x;          // local copy of revolve_about_x
  seg_t  offered_q[$];    // segments put on the bus, in order
  area_t area_q[$];       // predicted areas waiting for their beat
  int    err_cnt;
  int    cycle_cnt;
  bit    hold_req;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYC) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // round half up, then shift; saturates to all ones past 64 bits
  function automatic logic [63:0] round_down(logic [127:0] v, int unsigned sh);
    logic [128:0] t;
    t = ({1'b0, v} + (129'(1) << (sh - 1))) >> sh;
    return (t[128:64] != '0) ? '1 : t[63:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] v);
    logic [63:0]  root;
    logic [63:0]  cand;
    logic [127:0] sq;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'(1) << b);
      sq   = {64'b0, cand} * {64'b0, cand};
      if (sq <= v) root = cand;
    end
    return root;
  endfunction

  function automatic logic [63:0] mag64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // swept area of one segment
  function automatic area_t swept_area(seg_t s, logic about_x);
    area_t o;
    longint a0, r0, a1, r1, t, d, dr, s0, s1, n;
    logic [63:0] da, mag, m0, m1, ad, ratio, len, p;
    logic [127:0] q;
    logic neg;
    o.unsup = 1'b0;
    if (!s.is_line) begin
      o.area  = '0;
      o.unsup = 1'b1;
      return o;
    end
    if (about_x) begin
      a0 = s.x_start; r0 = s.y_start; a1 = s.x_end; r1 = s.y_end;
    end else begin
      a0 = s.y_start; r0 = s.x_start; a1 = s.y_end; r1 = s.x_end;
    end
    if (a1 < a0) begin
      t = a0; a0 = a1; a1 = t;
      t = r0; r0 = r1; r1 = t;
    end
    da = 64'(a1 - a0);
    if (da == 0) begin
      // annulus
      if (r1 < r0) begin
        t = r0; r0 = r1; r1 = t;
      end
      d   = r1 * r1 - r0 * r0;
      neg = d < 0;
      mag = round_down({64'b0, mag64(d)} * {64'b0, rssa_pkg::PI_Q61},
                       rssa_pkg::SH_ANNULUS);
    end else begin
      dr = r1 - r0;
      if (dr == 0) begin
        // cylinder
        neg = r0 < 0;
        mag = round_down({64'b0, mag64(r0) * da} * {64'b0, rssa_pkg::PI_Q61},
                         rssa_pkg::SH_CYLINDER);
      end else begin
        // difference of two cones
        m0 = mag64(r0);
        m1 = mag64(r1);
        ad = mag64(dr);
        s0 = r0 * longint'(m0);
        s1 = r1 * longint'(m1);
        n  = (m0 < m1) ? s1 - s0 : s0 - s1;
        neg = n < 0;
        q = ({64'b0, mag64(n)} << 30) / {64'b0, ad};
        ratio = (q[127:64] != '0) ? '1 : q[63:0];
        len = floor_sqrt(({64'b0, da} * {64'b0, da} + {64'b0, ad} * {64'b0, ad}) << 60);
        q   = {64'b0, len} * {64'b0, ratio};
        p   = q[127:64];
        mag = round_down({64'b0, p} * {64'b0, rssa_pkg::PI_Q61}, rssa_pkg::SH_CONE);
      end
    end
    if (neg) o.area = (mag > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : -mag;
    else     o.area = (mag > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : mag;
    return o;
  endfunction

  // predict on every accepted segment beat
  always @(posedge clk) begin
    seg_t  s;
    area_t e;
    if (rst_n && seg.valid && seg.ready) begin
      s = offered_q.pop_front();
      e = swept_area(s, axis_x);
      if (s.typed) begin
        e.area  = s.typed_area;
        e.unsup = s.typed_unsup;
      end
      area_q.push_back(e);
    end
  end

  // check every accepted area beat
  always @(posedge clk) begin
    area_t e;
    if (rst_n && res.valid && res.ready) begin
      if (area_q.size() == 0) begin
        $error("area beat with nothing expected: area=%0d", res.area);
        err_cnt++;
      end else begin
        e = area_q.pop_front();
        if (res.area !== e.area) begin
          $error("area: expected %0d, got %0d", e.area, res.area);
          err_cnt++;
        end
        if (res.unsupported_cell !== e.unsup) begin
          $error("unsupported_cell: expected %0b, got %0b", e.unsup, res.unsupported_cell);
          err_cnt++;
        end
      end
    end
  end

  // result side stall pattern, with a single long hold-off on request
  initial begin
    int mode, left;
    res.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      left = $urandom_range(20, 300);
      while (left > 0) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          res.ready <= 1'b0;
          repeat (250) @(posedge clk);
        end
        case (mode)
          0:       res.ready <= 1'b1;
          1:       res.ready <= ($urandom_range(0, 9) < 7);
          2:       res.ready <= (left % 4 != 0);
          default: res.ready <= ($urandom_range(0, 9) < 2);
        endcase
        left--;
      end
    end
  end

  task automatic reg_write(logic [rssa_pkg::PADDR_W-1:0] addr,
                           logic [rssa_pkg::PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (area_q.size() != 0) @(posedge clk);
  endtask

  // change the axis only while nothing is in flight
  task automatic set_axis(logic v);
    wait_drained();
    repeat (LATENCY) @(posedge clk);
    reg_write(rssa_pkg::PADDR_W'({rssa_pkg::REG_REVOLVE_ABOUT_X, 2'b00}),
              rssa_pkg::PDATA_W'(v));
    axis_x = v;
  endtask

  // put one segment beat on the bus and wait for it to be taken
  task automatic send_seg(seg_t s);
    offered_q.push_back(s);
    seg.valid   <= 1'b1;
    seg.x_start <= s.x_start;
    seg.y_start <= s.y_start;
    seg.x_end   <= s.x_end;
    seg.y_end   <= s.y_end;
    seg.is_line <= s.is_line;
    @(posedge clk);
    while (!seg.ready) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    seg.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic seg_t mk(logic signed [31:0] xs, logic signed [31:0] ys,
                              logic signed [31:0] xe, logic signed [31:0] ye,
                              logic ln);
    seg_t s;
    s = '{xs, ys, xe, ye, ln, 1'b0, 64'sd0, 1'b0};
    return s;
  endfunction

  function automatic seg_t mk_typed(seg_t s, logic signed [63:0] a, logic u);
    s.typed       = 1'b1;
    s.typed_area  = a;
    s.typed_unsup = u;
    return s;
  endfunction

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      2:       return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      3:       return 32'sd0;
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  // random segment; most are lines, some with a shared x or y coordinate or both
  function automatic seg_t rnd_seg();
    seg_t s;
    s = mk(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), 1'b1);
    case ($urandom_range(0, 9))
      0: s.is_line = 1'b0;
      1: begin
        s.x_end = s.x_start;
        s.y_end = s.y_start;
      end
      2: s.x_end = s.x_start;
      3: s.y_end = s.y_start;
      default: ;
    endcase
    return s;
  endfunction

  initial begin
    seg_t table_q[$];
    int   burst;
    bit   held;
    bit   paused;
    err_cnt    = 0;
    hold_req   = 1'b0;
    held       = 1'b0;
    paused     = 1'b0;
    axis_x     = rssa_pkg::REVOLVE_RESET;
    rst_n      = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    seg.valid  = 1'b0;
    seg.x_start = '0;
    seg.y_start = '0;
    seg.x_end   = '0;
    seg.y_end   = '0;
    seg.is_line = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    table_q.push_back(mk_typed(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1, 32'sh2, 1'b0),
                               64'sd0, 1'b1));
    table_q.push_back(mk_typed(mk(32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b1), 64'sd0, 1'b0));
    table_q.push_back(mk_typed(mk(32'sh0001_0000, 32'sh0003_0000, 32'sh0001_0000,
                                  32'sh0003_0000, 1'b1), 64'sd0, 1'b0));
    table_q.push_back(mk(32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0002_0000, 1'b1));
    table_q.push_back(mk(32'sh0, 32'sh0002_0000, 32'sh0, 32'sh0001_0000, 1'b1));
    table_q.push_back(mk(32'sh0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b1));
    table_q.push_back(mk(32'sh0, -32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000, 1'b1));
    table_q.push_back(mk(32'sh0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, 1'b1));
    table_q.push_back(mk(32'sh0001_0000, 32'sh0002_0000, 32'sh0, 32'sh0001_0000, 1'b1));
    table_q.push_back(mk(32'sh0, -32'sh0001_0000, 32'sh0001_0000, -32'sh0002_0000, 1'b1));
    table_q.push_back(mk(32'sh0, -32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b1));
    table_q.push_back(mk(32'sh0, -32'sh0002_0000, 32'sh0003_0000, 32'sh0001_0000, 1'b1));
    table_q.push_back(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                         32'sh8000_0000, 1'b1));
    table_q.push_back(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                         32'sh7FFF_FFFF, 1'b1));
    table_q.push_back(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                         32'sh7FFF_FFFF, 1'b1));
    table_q.push_back(mk(32'sh0, 32'sh8000_0000, 32'sh0, 32'sh7FFF_FFFF, 1'b1));
    table_q.push_back(mk(32'sh0, 32'sh1, 32'sh1, 32'sh0, 1'b1));
    table_q.push_back(mk(32'sh7FFF_FFFF, 32'sh0, 32'sh8000_0000, 32'sh1, 1'b1));
    table_q.push_back(mk(32'sh0001_0000, 32'sh0, 32'sh0003_0000, 32'sh0, 1'b1));

    // table under both axis settings
    for (int ph = 0; ph < 2; ph++) begin
      if (ph == 1) set_axis(1'b0);
      foreach (table_q[i]) begin
        if (ph == 1 && table_q[i].typed && table_q[i].is_line &&
            table_q[i].x_start != table_q[i].x_end) table_q[i].typed = 1'b0;
        send_seg(table_q[i]);
      end
      idle_gap(0);
    end

    // random phases, extremes of the axis register included
    for (int ph = 0; ph < 4; ph++) begin
      set_axis(ph[0]);
      for (int i = 0; i < RAND_SEGS / 4; ) begin
        if (i >= 50 && ph == 1 && !held) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        if (i >= 200 && ph == 2 && !paused) begin
          paused = 1'b1;
          idle_gap(1);
          wait_drained();
        end
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst && i < RAND_SEGS / 4; k++, i++) send_seg(rnd_seg());
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
      end
      idle_gap(0);
    end

    wait_drained();
    repeat (LATENCY) @(posedge clk);
    if (area_q.size() != 0 || err_cnt != 0) begin
      if (area_q.size() != 0) $error("%0d area beats never arrived", area_q.size());
      $display("DONE: errors detected");
    end else begin
      $display("DONE: 0 errors");
    end
    $finish;
  end

endmodule
